// ===== sv/pcxrle_pkg.sv =====
package pcxrle_pkg;

	localparam int RegAddrW = 5;
	localparam int RegIdxW  = 3;

	localparam logic [RegIdxW-1:0] REG_RLE_ENABLE    = 3'd0;
	localparam logic [RegIdxW-1:0] REG_BPS_CODE      = 3'd1;
	localparam logic [RegIdxW-1:0] REG_NUM_PLANES    = 3'd2;
	localparam logic [RegIdxW-1:0] REG_BYTES_PER_LN  = 3'd3;
	localparam logic [RegIdxW-1:0] REG_IMAGE_WIDTH   = 3'd4;
	localparam logic [RegIdxW-1:0] REG_IMAGE_HEIGHT  = 3'd5;
	localparam logic [RegIdxW-1:0] REG_GRAY_EXPAND   = 3'd6;

	localparam logic [1:0] RUN_CODE_TAG = 2'b11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	function automatic logic [63:0] unpack_samples(
		input logic [7:0] value,
		input logic [1:0] code,
		input logic       gray,
		input logic [3:0] nvalid
	);
		logic [63:0] packed_s;
		logic [7:0]  sh;
		logic [7:0]  lane;
		packed_s = '0;
		for (int i = 0; i < 8; i++) begin
			sh = value << (i << code);
			case (code)
				2'd0: lane = gray ? {8{sh[7]}} : {7'd0, sh[7]};
				2'd1: lane = gray ? {4{sh[7:6]}} : {6'd0, sh[7:6]};
				2'd2: lane = gray ? {2{sh[7:4]}} : {4'd0, sh[7:4]};
				default: lane = sh;
			endcase
			if (4'(i) < nvalid) begin
				packed_s[8*i +: 8] = lane;
			end
		end
		return packed_s;
	endfunction

endpackage

// ===== sv/pcx_rle_scanline_decoder.sv =====
// Channel   Direction  Handshake            Payload
// config    in/out     psel/penable/pready  paddr, pwdata, prdata
// request   in         in_valid/in_stall    cmd, data_byte
// result    out        out_valid/out_stall  row, plane, first_column, valid_samples,
//                                           samples, last_of_run, image_done
// A start command or count code is taken without leaving idle. A literal, or a run of n
// copies, makes one placement per cycle through the shared placement unit unless a stall
// holds it, then releases the held final result.
// in_stall is high while a request is being expanded; out_stall pauses placement only
// when a held result must move to the full output register.
// arst_n clears position, sequencer and valids and loads register defaults.
module pcx_rle_scanline_decoder
	import pcxrle_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [RegAddrW-1:0] paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic [7:0]          data_byte,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         row,
	output logic [1:0]          plane,
	output logic [15:0]         first_column,
	output logic [3:0]          valid_samples,
	output logic [63:0]         samples,
	output logic                last_of_run,
	output logic                image_done
);

	logic        rle_enable_q;
	logic [1:0]  bps_code_q;
	logic [2:0]  num_planes_q;
	logic [15:0] bytes_per_line_q;
	logic [15:0] image_width_q;
	logic [15:0] image_height_q;
	logic        gray_expand_q;

	logic        awaiting_q;
	logic [5:0]  stored_cnt_q;
	logic [15:0] bil_q;
	logic [1:0]  plane_idx_q;
	logic [15:0] row_idx_q;
	logic        finished_q;

	state_t      state_q, state_d;
	logic [5:0]  remain_q;
	logic [7:0]  value_q;

	logic        pend_vld_q;
	logic [15:0] pend_row_q;
	logic [1:0]  pend_plane_q;
	logic [15:0] pend_first_q;
	logic [3:0]  pend_nvalid_q;
	logic [63:0] pend_samples_q;
	logic        pend_done_q;

	logic        out_vld_q;
	logic [15:0] out_row_q;
	logic [1:0]  out_plane_q;
	logic [15:0] out_first_q;
	logic [3:0]  out_nvalid_q;
	logic [63:0] out_samples_q;
	logic        out_last_q;
	logic        out_done_q;

	logic                cfg_wr;
	logic [RegIdxW-1:0]  cfg_idx;

	logic [2:0]  eff_planes;
	logic [15:0] eff_height;

	logic        in_acc;
	logic        pos_ok;
	logic        code_case;
	logic        run_case;
	logic        lit_case;
	logic        launch;

	logic [18:0] first;
	logic [3:0]  spb;
	logic        vis;
	logic [18:0] diff;
	logic [3:0]  nvalid;
	logic [63:0] samples_new;
	logic        done_new;
	logic [16:0] bil_inc;
	logic [2:0]  plane_inc;
	logic [16:0] row_inc;
	logic        bil_wrap;
	logic        plane_wrap;
	logic        row_wrap;

	logic        out_free;
	logic        blocked;
	logic        run_step;
	logic        run_end;
	logic        flush_go;
	logic        load_out;

	assign cfg_idx = paddr[RegAddrW-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_comb begin
		case (cfg_idx)
			REG_RLE_ENABLE:   prdata = {31'd0, rle_enable_q};
			REG_BPS_CODE:     prdata = {30'd0, bps_code_q};
			REG_NUM_PLANES:   prdata = {29'd0, num_planes_q};
			REG_BYTES_PER_LN: prdata = {16'd0, bytes_per_line_q};
			REG_IMAGE_WIDTH:  prdata = {16'd0, image_width_q};
			REG_IMAGE_HEIGHT: prdata = {16'd0, image_height_q};
			REG_GRAY_EXPAND:  prdata = {31'd0, gray_expand_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_enable_q     <= 1'b1;
			bps_code_q       <= 2'd3;
			num_planes_q     <= 3'd1;
			bytes_per_line_q <= 16'd1;
			image_width_q    <= 16'd1;
			image_height_q   <= 16'd1;
			gray_expand_q    <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_RLE_ENABLE:   rle_enable_q     <= pwdata[0];
				REG_BPS_CODE:     bps_code_q       <= pwdata[1:0];
				REG_NUM_PLANES:   num_planes_q     <= pwdata[2:0];
				REG_BYTES_PER_LN: bytes_per_line_q <= pwdata[15:0];
				REG_IMAGE_WIDTH:  image_width_q    <= pwdata[15:0];
				REG_IMAGE_HEIGHT: image_height_q   <= pwdata[15:0];
				REG_GRAY_EXPAND:  gray_expand_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (num_planes_q == 3'd0) begin
			eff_planes = 3'd1;
		end else if (num_planes_q > 3'd4) begin
			eff_planes = 3'd4;
		end else begin
			eff_planes = num_planes_q;
		end
	end
	assign eff_height = (image_height_q == 16'd0) ? 16'd1 : image_height_q;

	// request decode
	assign in_acc    = in_valid && !in_stall;
	assign pos_ok    = !finished_q && (row_idx_q < eff_height);
	assign run_case  = rle_enable_q && awaiting_q;
	assign code_case = rle_enable_q && !awaiting_q && (data_byte[7:6] == RUN_CODE_TAG);
	assign lit_case  = !run_case && !code_case;
	assign launch    = !cmd && pos_ok && ((run_case && stored_cnt_q != 6'd0) || lit_case);

	// shared placement unit
	assign spb   = 4'd8 >> bps_code_q;
	assign first = {bil_q, 3'd0} >> bps_code_q;
	assign vis   = first < {3'd0, image_width_q};
	assign diff  = {3'd0, image_width_q} - first;
	assign nvalid = (diff > {15'd0, spb}) ? spb : diff[3:0];
	assign samples_new = unpack_samples(value_q, bps_code_q, gray_expand_q, nvalid);
	assign done_new = ({1'b0, row_idx_q} + 17'd1 >= {1'b0, eff_height})
		&& ({1'b0, plane_idx_q} + 3'd1 >= eff_planes)
		&& ({1'b0, first} + {16'd0, spb} >= {4'd0, image_width_q});

	assign bil_inc    = {1'b0, bil_q} + 17'd1;
	assign plane_inc  = {1'b0, plane_idx_q} + 3'd1;
	assign row_inc    = {1'b0, row_idx_q} + 17'd1;
	assign bil_wrap   = bil_inc >= {1'b0, bytes_per_line_q};
	assign plane_wrap = plane_inc >= eff_planes;
	assign row_wrap   = row_inc >= {1'b0, eff_height};

	assign out_free = !out_vld_q || !out_stall;
	assign blocked  = vis && pend_vld_q && !out_free;

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc && launch) state_d = ST_RUN;
			ST_RUN:   if (run_end) state_d = ST_FLUSH;
			ST_FLUSH: if (flush_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		run_step = (state_q == ST_RUN) && !blocked;
		run_end  = run_step && ((remain_q == 6'd1) || (bil_wrap && plane_wrap && row_wrap));
		flush_go = (state_q == ST_FLUSH) && (!pend_vld_q || out_free);
		load_out = (run_step && vis && pend_vld_q) || (flush_go && pend_vld_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// position and run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q   <= 1'b0;
			stored_cnt_q <= '0;
			bil_q        <= '0;
			plane_idx_q  <= '0;
			row_idx_q    <= '0;
			finished_q   <= 1'b0;
			remain_q     <= '0;
		end else if (in_acc) begin
			if (cmd) begin
				awaiting_q   <= 1'b0;
				stored_cnt_q <= '0;
				bil_q        <= '0;
				plane_idx_q  <= '0;
				row_idx_q    <= '0;
				finished_q   <= 1'b0;
			end else if (!finished_q && !pos_ok) begin
				finished_q <= 1'b1;
			end else if (pos_ok) begin
				if (code_case) begin
					stored_cnt_q <= data_byte[5:0];
					awaiting_q   <= 1'b1;
				end else begin
					awaiting_q <= 1'b0;
					remain_q   <= run_case ? stored_cnt_q : 6'd1;
				end
			end
		end else if (run_step) begin
			remain_q <= remain_q - 6'd1;
			if (bil_wrap) begin
				bil_q <= '0;
				if (plane_wrap) begin
					plane_idx_q <= '0;
					row_idx_q   <= row_inc[15:0];
					if (row_wrap) begin
						finished_q <= 1'b1;
					end
				end else begin
					plane_idx_q <= plane_inc[1:0];
				end
			end else begin
				bil_q <= bil_inc[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			value_q <= data_byte;
		end
	end

	// hold the newest result until the next one or the end of the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (run_step && vis) begin
			pend_vld_q <= 1'b1;
		end else if (flush_go) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run_step && vis) begin
			pend_row_q     <= row_idx_q;
			pend_plane_q   <= plane_idx_q;
			pend_first_q   <= first[15:0];
			pend_nvalid_q  <= nvalid;
			pend_samples_q <= samples_new;
			pend_done_q    <= done_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_row_q     <= pend_row_q;
			out_plane_q   <= pend_plane_q;
			out_first_q   <= pend_first_q;
			out_nvalid_q  <= pend_nvalid_q;
			out_samples_q <= pend_samples_q;
			out_done_q    <= pend_done_q;
			out_last_q    <= (state_q == ST_FLUSH);
		end
	end

	assign out_valid     = out_vld_q;
	assign row           = out_row_q;
	assign plane         = out_plane_q;
	assign first_column  = out_first_q;
	assign valid_samples = out_nvalid_q;
	assign samples       = out_samples_q;
	assign last_of_run   = out_last_q;
	assign image_done    = out_done_q;

endmodule
